// File: hw/rtl/rgb555_color_math_unit_defines.svh
// assertion macros for the rgb555 color math unit
// used by rgb555_color_math_unit.sv, no other dependencies
`ifndef RGB555_COLOR_MATH_UNIT_DEFINES_SVH
`define RGB555_COLOR_MATH_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle, consequent may hold a delay
`define RCM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define RCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/rcm_pkg.sv
// shared types and constants for the rgb555 color math unit
// no dependencies
`default_nettype none

package rcm_pkg;

   localparam int unsigned CHAN_W  = 5;
   localparam int unsigned COLOR_W = 15;
   localparam int unsigned ALPHA_W = 4;
   localparam int unsigned CMD_W   = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_SUB   = 2'd1,
      CMD_MUL   = 2'd2,
      CMD_BLEND = 2'd3
   } cmd_type;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 5'd31;
   localparam logic [CHAN_W:0]   ALPHA_ONE = 6'd16;

   // per-channel results of all four operations
   typedef struct packed {
      logic [CHAN_W-1:0] add_res;
      logic [CHAN_W-1:0] sub_res;
      logic [CHAN_W-1:0] mul_res;
      logic [CHAN_W-1:0] blend_res;
   } lane_res_type;

endpackage

`default_nettype wire

// File: hw/rtl/rcm_lane.sv
// one 5-bit channel lane: products and sums, then clamping (two stages)
// depends on rcm_pkg
`default_nettype none

module rcm_lane (
   input  wire logic                            clock,
   input  wire logic [rcm_pkg::CHAN_W-1:0]      a,
   input  wire logic [rcm_pkg::CHAN_W-1:0]      b,
   input  wire logic [rcm_pkg::ALPHA_W-1:0]     alpha,
   output rcm_pkg::lane_res_type                res
);

   logic [rcm_pkg::CHAN_W:0]     alpha_comp;
   logic [rcm_pkg::CHAN_W:0]     sum_in,  sum_ff;
   logic [rcm_pkg::CHAN_W:0]     diff_in, diff_ff;
   logic [2*rcm_pkg::CHAN_W-1:0] prod_in, prod_ff;
   logic [8:0]                   wa_in,   wa_ff;
   logic [8:0]                   wb_in,   wb_ff;
   logic [9:0]                   mix;
   rcm_pkg::lane_res_type        res_in,  res_ff;

   // stage 1: raw sums and products
   always_comb begin
      alpha_comp = rcm_pkg::ALPHA_ONE - {2'b00, alpha};
      sum_in     = {1'b0, a} + {1'b0, b};
      diff_in    = {1'b0, a} - {1'b0, b};
      prod_in    = {5'd0, a} * {5'd0, b};
      wa_in      = 9'({4'd0, a} * {5'd0, alpha});
      wb_in      = 9'({4'd0, b} * {3'd0, alpha_comp});
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      wa_ff   <= wa_in;
      wb_ff   <= wb_in;
   end

   // stage 2: saturate and scale
   always_comb begin
      mix              = {1'b0, wa_ff} + {1'b0, wb_ff};
      res_in.add_res   = sum_ff[rcm_pkg::CHAN_W] ? rcm_pkg::CHAN_MAX
                                                 : sum_ff[rcm_pkg::CHAN_W-1:0];
      res_in.sub_res   = diff_ff[rcm_pkg::CHAN_W] ? '0 : diff_ff[rcm_pkg::CHAN_W-1:0];
      res_in.mul_res   = prod_ff[9] ? rcm_pkg::CHAN_MAX : prod_ff[8:4];
      res_in.blend_res = mix[8:4];
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rgb555_color_math_unit.sv
// rgb555 color math unit: three pipeline stages
// an item is taken every cycle, busy stays low, results cannot be held off
// rsp_valid strobes for one cycle per start, once the start has passed the v1, v2 and v3 valid registers
// synchronous active-high reset clears the valid pipeline only
// depends on rcm_pkg, rcm_lane and rgb555_color_math_unit_defines.svh
`default_nettype none
`include "rgb555_color_math_unit_defines.svh"

module rgb555_color_math_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic [rcm_pkg::CMD_W-1:0]     req_command,
   input  wire logic [rcm_pkg::COLOR_W-1:0]   req_color_a,
   input  wire logic [rcm_pkg::COLOR_W-1:0]   req_color_b,
   input  wire logic [rcm_pkg::ALPHA_W-1:0]   req_alpha,
   output      logic                          rsp_valid,
   output      logic [rcm_pkg::COLOR_W-1:0]   rsp_color_out
);

   // valid bits that travel with each word
   logic v1_in, v1_ff;
   logic v2_in, v2_ff;
   logic v3_in, v3_ff;

   // command follows the lanes through stages 1 and 2
   rcm_pkg::cmd_type cmd1_ff, cmd2_ff;

   rcm_pkg::lane_res_type lane_res [3];
   logic [rcm_pkg::CHAN_W-1:0] chan_sel [3];
   logic [rcm_pkg::COLOR_W-1:0] color_in, color_ff;

   // the pipeline never stalls, so every start is taken
   assign busy = 1'b0;

   assign v1_in = start;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd1_ff <= rcm_pkg::cmd_type'(req_command);
      cmd2_ff <= cmd1_ff;
   end

   // one lane per channel: red 14-10, green 9-5, blue 4-0
   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      rcm_lane u_lane (
         .clock (clock),
         .a     (req_color_a[ch*rcm_pkg::CHAN_W +: rcm_pkg::CHAN_W]),
         .b     (req_color_b[ch*rcm_pkg::CHAN_W +: rcm_pkg::CHAN_W]),
         .alpha (req_alpha),
         .res   (lane_res[ch])
      );
   end

   // stage 3: pick the operation and pack the color
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         case (cmd2_ff)
            rcm_pkg::CMD_ADD:   chan_sel[ch] = lane_res[ch].add_res;
            rcm_pkg::CMD_SUB:   chan_sel[ch] = lane_res[ch].sub_res;
            rcm_pkg::CMD_MUL:   chan_sel[ch] = lane_res[ch].mul_res;
            rcm_pkg::CMD_BLEND: chan_sel[ch] = lane_res[ch].blend_res;
            default:            chan_sel[ch] = lane_res[ch].add_res;
         endcase
      end
      color_in = {chan_sel[2], chan_sel[1], chan_sel[0]};
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
   end

   assign rsp_valid     = v3_ff;
   assign rsp_color_out = color_ff;

   // every accepted word comes out on rsp_valid
   `RCM_ASSERT_IMPLIES(a_latency, clock, reset, start && !busy, ##3 rsp_valid, "result missing after start")
   `RCM_ASSERT_NEXT(a_no_stray, clock, reset, !start, ##2 !rsp_valid, "result without a start")
   // blend at zero weight passes color_b through
   `RCM_ASSERT_IMPLIES(a_blend_zero, clock, reset, start && (req_command == rcm_pkg::CMD_BLEND) && (req_alpha == '0), ##3 (rsp_color_out == $past(req_color_b, 3)), "blend alpha zero mismatch")
   // subtract of a color from itself is black
   `RCM_ASSERT_IMPLIES(a_sub_self, clock, reset, start && (req_command == rcm_pkg::CMD_SUB) && (req_color_a == req_color_b), ##3 (rsp_color_out == '0), "self subtract not zero")

endmodule

`default_nettype wire
